// File: hdl/upd_pkg.sv
// Types, constants and helper functions shared by the URL path percent decoder.
package upd_pkg;

	// Special path characters
	localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
	localparam logic [7:0] CH_FRAG  = 8'h23;  // '#'
	localparam logic [7:0] CH_PCT   = 8'h25;  // '%'

	// Max results one input beat can cause
	localparam int unsigned MAX_RES = 3;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,  // plain bytes
		PH_PCT   = 2'd1,  // seen '%'
		PH_DIGIT = 2'd2,  // seen '%' and one hex digit
		PH_DROP  = 2'd3   // dropping query or fragment
	} phase_t;

	// Results produced by one input beat
	typedef struct packed {
		logic [1:0]                 n;
		logic [MAX_RES-1:0][7:0]    byt;
		logic [MAX_RES-1:0]         has;
		logic [MAX_RES-1:0]         last;
	} emit_t;

	// One queued output beat
	typedef struct packed {
		logic [7:0] byt;
		logic       has;
		logic       last;
	} res_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	// Nibble value of a hex digit; only meaningful when is_hex is true
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		if (c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c <= 8'h46) begin
			d = c - 8'h37;
		end else begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

	// Append one data byte to the result list
	function automatic emit_t add_byte(input emit_t e, input logic [7:0] b);
		emit_t r;
		r = e;
		for (int i = 0; i < MAX_RES; i++) begin
			if (e.n == 2'(i)) begin
				r.byt[i] = b;
				r.has[i] = 1'b1;
			end
		end
		r.n = e.n + 2'd1;
		return r;
	endfunction

endpackage

// File: hdl/url_path_percent_decoder.sv
// URL path percent decoder: top level with decode logic and result queue.
//
// Input channel (in_valid/in_ready, in_byte, in_last) takes raw path bytes,
// in_last flags the final byte of a path. Output channel (out_valid/out_ready,
// out_byte, has_byte, out_last) gives decoded bytes one beat at a time; a beat
// with has_byte low is a bare end marker that only carries out_last.
// Each input beat is decoded in the cycle it is accepted and its 0 to 3 results
// are written into a 4-entry result queue; the output is read from the queue
// registers, not straight from the decode logic.
// Throughput: one input beat per cycle while the output drains one beat per
// cycle. Input is taken while the queue holds at most one result, so a beat
// that causes two or three results (broken escapes) holds off further input
// until the queue drains back to one result.
// When the receiver stalls, the queue fills and in_ready drops once two or
// more results wait. Reset empties the queue and returns the decoder to idle.
module url_path_percent_decoder
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;
	emit_t      em;

	res_t       fifo_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	logic       acc, pop;
	logic [1:0] push_n;

	assign in_ready  = (count_q <= 3'd1);
	assign acc       = in_valid && in_ready;
	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign push_n    = acc ? em.n : 2'd0;

	// Decode one byte: next phase and result list
	always_comb begin
		phase_t ph;
		em      = '0;
		ph      = phase_q;
		held_d  = held_q;
		if (ph == PH_DROP) begin
			// dropping
		end else if (in_byte == CH_QUERY || in_byte == CH_FRAG) begin
			if (ph == PH_PCT) begin
				em = add_byte(em, CH_PCT);
			end else if (ph == PH_DIGIT) begin
				em = add_byte(em, CH_PCT);
				em = add_byte(em, held_q);
			end
			ph = PH_DROP;
		end else if (ph == PH_IDLE) begin
			if (in_byte == CH_PCT) ph = PH_PCT;
			else em = add_byte(em, in_byte);
		end else if (ph == PH_PCT) begin
			if (is_hex(in_byte)) begin
				held_d = in_byte;
				ph     = PH_DIGIT;
			end else begin
				em = add_byte(em, CH_PCT);
				if (in_byte == CH_PCT) begin
					ph = PH_PCT;
				end else begin
					em = add_byte(em, in_byte);
					ph = PH_IDLE;
				end
			end
		end else begin
			// held digit is always hex here
			if (is_hex(in_byte)) begin
				em = add_byte(em, {hex_val(held_q), hex_val(in_byte)});
				ph = PH_IDLE;
			end else begin
				em = add_byte(em, CH_PCT);
				em = add_byte(em, held_q);
				if (in_byte == CH_PCT) begin
					ph = PH_PCT;
				end else begin
					em = add_byte(em, in_byte);
					ph = PH_IDLE;
				end
			end
		end

		// End of path: flush pending escape, mark final result (a bare end marker if none)
		if (in_last) begin
			if (ph == PH_PCT) begin
				em = add_byte(em, CH_PCT);
			end else if (ph == PH_DIGIT) begin
				em = add_byte(em, CH_PCT);
				em = add_byte(em, held_d);
			end
			if (em.n == 2'd0) begin
				em.n = 2'd1;
			end
			for (int i = 0; i < MAX_RES; i++) begin
				if (em.n == 2'(i + 1)) em.last[i] = 1'b1;
			end
			ph     = PH_IDLE;
			held_d = '0;
		end
		phase_d = ph;
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			logic [1:0] off;
			off = 2'(k) - wr_ptr_q;
			if (acc && off < em.n) begin
				fifo_q[k] <= '{byt: em.byt[off], has: em.has[off], last: em.last[off]};
			end
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	assign out_byte = fifo_q[rd_ptr_q].byt;
	assign has_byte = fifo_q[rd_ptr_q].has;
	assign out_last = fifo_q[rd_ptr_q].last;

	// Queue never overflows
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue count above depth");

	// A final input beat always queues at least one result
	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |-> em.n != 2'd0)
		else $error("final beat produced no result");

	// After a final beat the decoder is back in idle with no held digit
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |=> phase_q == PH_IDLE && held_q == 8'h00)
		else $error("decoder not idle after end of path");

	// A held digit is always a hex digit
	a_held_hex: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIGIT |-> is_hex(held_q))
		else $error("held digit is not hex");

	// An accepted beat that queues results makes out_valid high in the next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		acc && em.n != 2'd0 |=> out_valid)
		else $error("queued result not visible");

endmodule
